FILE: sv/contiguous_fit_block_allocator_defines.svh
// Assertion helpers shared by the allocator RTL.
// Every check is clocked on i_clk and is off while i_rst_n is low.
`ifndef CONTIGUOUS_FIT_BLOCK_ALLOCATOR_DEFINES_SVH
`define CONTIGUOUS_FIT_BLOCK_ALLOCATOR_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CFBA_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CFBA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/cfba_pkg.sv
`default_nettype none

package cfba_pkg;

    // Field widths of the stream words.
    localparam int KIND_W   = 2;
    localparam int START_W  = 10;
    localparam int LEN_W    = 11;
    localparam int STATUS_W = 2;
    localparam int DATA_W   = 24;
    localparam int PAD_W    = DATA_W - START_W - LEN_W;

    // Request kinds.
    localparam logic [KIND_W-1:0] KIND_ALLOC = 2'd0;
    localparam logic [KIND_W-1:0] KIND_FREE  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CLAIM = 2'd2;

    // Result status codes.
    localparam logic [STATUS_W-1:0] STATUS_DONE  = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_NOFIT = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_BAD   = 2'd2;

    // Fit strategy register codes.
    localparam logic [1:0] FIT_FIRST = 2'd0;
    localparam logic [1:0] FIT_BEST  = 2'd1;
    localparam logic [1:0] FIT_NEXT  = 2'd2;
    localparam logic [1:0] FIT_WORST = 2'd3;

    // Sequencer states.
    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_MARK,
        S_FREE,
        S_DONE
    } t_state;

    // What the bitmap scan is looking for.
    typedef enum logic [1:0] {
        SM_FIT,
        SM_BEST,
        SM_WORST,
        SM_CLAIM
    } t_scan_mode;

endpackage

`default_nettype wire

FILE: sv/cfba_bit_ram.sv
`default_nettype none

// Single-port bitmap memory with a registered, read-first output.
module cfba_bit_ram #(
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic                     i_we,
    input  wire logic                     i_wd,
    output logic                          o_rd
);

    logic r_mem [DEPTH];
    logic r_rd;

    // A read at the written address returns the old bit.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wd;
        end
        r_rd <= r_mem[i_addr];
    end

    assign o_rd = r_rd;

endmodule

`default_nettype wire

FILE: sv/contiguous_fit_block_allocator.sv
`default_nettype none
`include "contiguous_fit_block_allocator_defines.svh"

// Contiguous block allocator over a used-block bitmap of BLOCKS entries, held in a
// single-port RAM that is visited one block per cycle. After reset the block runs a
// clearing pass over the whole bitmap before it takes its first word; configuration writes are
// taken at any time. An allocate scans the bitmap from block 0 (from the rover for next
// fit) until a fitting run is found; best and worst fit always scan all BLOCKS blocks.
// Next fit may scan further, as it may follow a run from a wrapped start past the rover.
// A found run is then marked block by block and the result is posted. A free clears its
// run block by block, a claim scans its run and then marks it, and a rejected request goes
// straight to posting its result. All of these steps share the single bitmap port.
// One request is in work at a time; a new word is taken while the previous result still waits.
module contiguous_fit_block_allocator
    import cfba_pkg::*;
#(
    parameter int BLOCKS = 1024
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    // Configuration: fit strategy.
    input  wire logic                i_cfg_valid,
    output logic                     o_cfg_ready,
    input  wire logic [1:0]          i_cfg_data,
    // Request stream.
    input  wire logic                s_axis_tvalid,
    output logic                     s_axis_tready,
    input  wire logic [DATA_W-1:0]   s_axis_tdata,   // run_start[9:0], run_length[20:10]
    input  wire logic [KIND_W-1:0]   s_axis_tuser,   // kind[1:0]
    // Result stream.
    output logic                     m_axis_tvalid,
    input  wire logic                m_axis_tready,
    output logic [DATA_W-1:0]        m_axis_tdata,   // found_start[9:0], used_count[20:10]
    output logic [STATUS_W-1:0]      m_axis_tuser    // status[1:0]
);

    localparam int AW = $clog2(BLOCKS);
    localparam int CW = $clog2(BLOCKS + 1);
    localparam int KW = CW + 1;
    localparam int EW = ((CW > LEN_W) ? CW : LEN_W) + 1;

    localparam logic [AW-1:0] LAST_IDX = AW'(BLOCKS - 1);
    localparam logic [CW-1:0] BLOCKS_C = CW'(BLOCKS);
    localparam logic [KW-1:0] BLOCKS_K = KW'(BLOCKS);
    localparam logic [EW-1:0] BLOCKS_E = EW'(BLOCKS);

    t_state                r_state,      n_state;
    t_scan_mode            r_mode,       n_mode;
    logic [1:0]            r_strategy,   n_strategy;
    logic [AW-1:0]         r_addr,       n_addr;
    logic [KW-1:0]         r_k,          n_k;
    logic [CW-1:0]         r_len,        n_len;
    logic [CW-1:0]         r_cnt,        n_cnt;
    logic [CW-1:0]         r_run,        n_run;
    logic [AW-1:0]         r_hstart,     n_hstart;
    logic [CW-1:0]         r_best,       n_best;
    logic [AW-1:0]         r_pick,       n_pick;
    logic                  r_has,        n_has;
    logic [CW-1:0]         r_used,       n_used;
    logic [AW-1:0]         r_rover,      n_rover;
    logic [STATUS_W-1:0]   r_status,     n_status;
    logic [AW-1:0]         r_found,      n_found;
    logic                  r_ev,         n_ev;
    logic [AW-1:0]         r_eidx,       n_eidx;
    logic                  r_eok,        n_eok;
    logic                  r_ewrap,      n_ewrap;
    logic                  r_elast,      n_elast;
    logic                  r_fv,         n_fv;
    logic                  r_out_valid,  n_out_valid;
    logic [STATUS_W-1:0]   r_out_status, n_out_status;
    logic [START_W-1:0]    r_out_found,  n_out_found;
    logic [LEN_W-1:0]      r_out_used,   n_out_used;

    logic                  ram_we;
    logic                  ram_wd;
    logic                  ram_rd;
    logic [AW-1:0]         ram_addr;

    logic [KIND_W-1:0]     in_kind;
    logic [START_W-1:0]    in_start;
    logic [LEN_W-1:0]      in_len;
    logic [EW-1:0]         in_start_e;
    logic [EW-1:0]         in_len_e;
    logic [EW-1:0]         in_end_e;
    logic                  len_zero;
    logic                  len_big;
    logic                  past_end;

    logic                  blk_free;
    logic [CW-1:0]         run_in;
    logic [CW-1:0]         run_new;
    logic [CW-1:0]         hole_len;
    logic [AW-1:0]         hs;
    logic                  succ;
    logic                  nofit;
    logic [AW-1:0]         succ_pos;
    logic [CW-1:0]         rover_sum;
    logic [EW-1:0]         found_e;
    logic [EW-1:0]         used_e;

    // Bitmap store.
    cfba_bit_ram #(
        .DEPTH (BLOCKS)
    ) u_map (
        .i_clk  (i_clk),
        .i_addr (ram_addr),
        .i_we   (ram_we),
        .i_wd   (ram_wd),
        .o_rd   (ram_rd)
    );

    // Unpack the request word and check its bounds.
    assign in_kind    = s_axis_tuser;
    assign in_start   = s_axis_tdata[START_W-1:0];
    assign in_len     = s_axis_tdata[START_W+LEN_W-1:START_W];
    assign in_start_e = EW'(in_start);
    assign in_len_e   = EW'(in_len);
    assign in_end_e   = in_start_e + in_len_e;
    assign len_zero   = (in_len == '0);
    assign len_big    = (in_len_e > BLOCKS_E);
    assign past_end   = (in_end_e > BLOCKS_E);

    // Scan evaluation of the bit that arrived from the memory.
    assign blk_free = !ram_rd;
    assign run_in   = r_ewrap ? '0 : r_run;
    assign run_new  = run_in + CW'(1);
    assign hole_len = blk_free ? run_new : run_in;
    assign hs       = (run_in == '0) ? r_eidx : r_hstart;

    assign found_e  = EW'(r_found);
    assign used_e   = EW'(n_used);

    // Sequencer: next state, memory control and result capture.
    always_comb begin
        n_state      = r_state;
        n_mode       = r_mode;
        n_strategy   = r_strategy;
        n_addr       = r_addr;
        n_k          = r_k;
        n_len        = r_len;
        n_cnt        = r_cnt;
        n_run        = r_run;
        n_hstart     = r_hstart;
        n_best       = r_best;
        n_pick       = r_pick;
        n_has        = r_has;
        n_used       = r_used;
        n_rover      = r_rover;
        n_status     = r_status;
        n_found      = r_found;
        n_out_valid  = r_out_valid;
        n_out_status = r_out_status;
        n_out_found  = r_out_found;
        n_out_used   = r_out_used;
        ram_we       = 1'b0;
        ram_wd       = 1'b0;
        ram_addr     = r_addr;
        succ         = 1'b0;
        nofit        = 1'b0;
        succ_pos     = hs;
        rover_sum    = '0;

        if (i_cfg_valid) begin
            n_strategy = i_cfg_data;
        end

        // A bit read back during a free pass that was set lowers the count.
        if (r_fv && ram_rd) begin
            n_used = r_used - CW'(1);
        end

        if (r_out_valid && m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_CLEAR: begin
                ram_we = 1'b1;
                n_addr = r_addr + AW'(1);
                if (r_addr == LAST_IDX) begin
                    n_addr  = '0;
                    n_state = S_IDLE;
                end
            end

            S_IDLE: begin
                if (s_axis_tvalid) begin
                    n_status = STATUS_BAD;
                    n_found  = '0;
                    n_len    = in_len_e[CW-1:0];
                    n_cnt    = in_len_e[CW-1:0];
                    n_k      = '0;
                    n_run    = '0;
                    n_hstart = '0;
                    n_best   = '0;
                    n_has    = 1'b0;
                    n_state  = S_DONE;
                    if (!len_zero) begin
                        case (in_kind)
                            KIND_ALLOC: begin
                                if (len_big) begin
                                    n_status = STATUS_NOFIT;
                                end else begin
                                    n_state = S_SCAN;
                                    n_addr  = (r_strategy == FIT_NEXT) ? r_rover : '0;
                                    case (r_strategy)
                                        FIT_BEST:  n_mode = SM_BEST;
                                        FIT_WORST: n_mode = SM_WORST;
                                        default:   n_mode = SM_FIT;
                                    endcase
                                end
                            end
                            KIND_FREE: begin
                                if (!past_end) begin
                                    n_state  = S_FREE;
                                    n_status = STATUS_DONE;
                                    n_addr   = in_start_e[AW-1:0];
                                    n_found  = in_start_e[AW-1:0];
                                end
                            end
                            KIND_CLAIM: begin
                                if (!past_end) begin
                                    n_state = S_SCAN;
                                    n_mode  = SM_CLAIM;
                                    n_addr  = in_start_e[AW-1:0];
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                end
            end

            S_SCAN: begin
                // Issue side: walk the bitmap with wrap.
                n_addr = (r_addr == LAST_IDX) ? '0 : r_addr + AW'(1);
                n_k    = r_k + KW'(1);
                if (r_ev) begin
                    n_run    = blk_free ? run_new : '0;
                    n_hstart = hs;
                    case (r_mode)
                        SM_BEST, SM_WORST: begin
                            // A hole closes at a used block or at the last block.
                            if ((!blk_free || r_elast) && (hole_len >= r_len)) begin
                                if ((r_mode == SM_BEST) ? (!r_has || hole_len <= r_best)
                                                        : (hole_len > r_best)) begin
                                    n_best = hole_len;
                                    n_pick = hs;
                                    n_has  = 1'b1;
                                end
                            end
                            if (r_elast) begin
                                succ     = n_has;
                                nofit    = !n_has;
                                succ_pos = n_pick;
                            end
                        end
                        default: begin
                            // New runs may start only within one lap of the store.
                            if (blk_free && (run_new == r_len) && (r_eok || run_in != '0)) begin
                                succ = 1'b1;
                            end else if (!r_eok && (!blk_free || run_in == '0)) begin
                                nofit = 1'b1;
                            end else if ((r_mode == SM_CLAIM) && !blk_free) begin
                                nofit = 1'b1;
                            end
                        end
                    endcase
                end
                if (succ) begin
                    n_state  = S_MARK;
                    n_status = STATUS_DONE;
                    n_found  = succ_pos;
                    n_addr   = succ_pos;
                    n_cnt    = r_len;
                    n_used   = r_used + r_len;
                    if ((r_mode == SM_FIT) && (r_strategy == FIT_NEXT)) begin
                        rover_sum = CW'(succ_pos) + r_len;
                        n_rover   = (rover_sum == BLOCKS_C) ? '0 : rover_sum[AW-1:0];
                    end
                end else if (nofit) begin
                    n_state  = S_DONE;
                    n_status = STATUS_NOFIT;
                    n_found  = '0;
                end
            end

            S_MARK: begin
                ram_we = 1'b1;
                ram_wd = 1'b1;
                n_addr = r_addr + AW'(1);
                n_cnt  = r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    n_state = S_DONE;
                end
            end

            S_FREE: begin
                ram_we = 1'b1;
                n_addr = r_addr + AW'(1);
                n_cnt  = r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    n_state = S_DONE;
                end
            end

            S_DONE: begin
                if (!r_out_valid || m_axis_tready) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_status;
                    n_out_found  = found_e[START_W-1:0];
                    n_out_used   = used_e[LEN_W-1:0];
                    n_state      = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase

        // Read pipeline tags: each bit arrives in the cycle after its address.
        n_ev    = (r_state == S_SCAN);
        n_eidx  = r_addr;
        n_eok   = (r_k < BLOCKS_K);
        n_ewrap = (r_addr == '0) && (r_k != '0);
        n_elast = (r_addr == LAST_IDX);
        n_fv    = (r_state == S_FREE);
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_strategy  <= FIT_FIRST;
            r_addr      <= '0;
            r_used      <= '0;
            r_rover     <= '0;
            r_ev        <= 1'b0;
            r_fv        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_strategy  <= n_strategy;
            r_addr      <= n_addr;
            r_used      <= n_used;
            r_rover     <= n_rover;
            r_ev        <= n_ev;
            r_fv        <= n_fv;
            r_out_valid <= n_out_valid;
        end
    end

    // Working and result registers.
    always_ff @(posedge i_clk) begin
        r_mode       <= n_mode;
        r_k          <= n_k;
        r_len        <= n_len;
        r_cnt        <= n_cnt;
        r_run        <= n_run;
        r_hstart     <= n_hstart;
        r_best       <= n_best;
        r_pick       <= n_pick;
        r_has        <= n_has;
        r_status     <= n_status;
        r_found      <= n_found;
        r_eidx       <= n_eidx;
        r_eok        <= n_eok;
        r_ewrap      <= n_ewrap;
        r_elast      <= n_elast;
        r_out_status <= n_out_status;
        r_out_found  <= n_out_found;
        r_out_used   <= n_out_used;
    end

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{PAD_W{1'b0}}, r_out_used, r_out_found};
    assign m_axis_tuser  = r_out_status;

    // Checks on the sequencer.
    `CFBA_ASSERT_SAME(a_used_bounded, 1'b1, r_used <= BLOCKS_C, "used count above store size")
    `CFBA_ASSERT_SAME(a_rover_bounded, 1'b1, r_rover <= LAST_IDX, "rover past last block")
    `CFBA_ASSERT_NEXT(a_result_held, (r_state == S_DONE) && r_out_valid && !m_axis_tready, (r_state == S_DONE), "pending result overwritten")

endmodule

`default_nettype wire

FILE: sim/allocator_checker.sv
`timescale 1ns / 1ps

// Watches the configuration, request and result channels of the allocator. It keeps its own
// copy of the used-block map, the next-fit rover and the fit strategy. Each accepted request
// word queues the result it must produce, and each accepted result word is compared field by
// field with the oldest queued one.
module allocator_checker
    import cfba_pkg::*;
#(
    parameter int BLOCKS = 1024
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_valid,
    input  logic                i_cfg_ready,
    input  logic [1:0]          i_cfg_data,
    input  logic                i_req_valid,
    input  logic                i_req_ready,
    input  logic [DATA_W-1:0]   i_req_data,     // run_start[9:0], run_length[20:10]
    input  logic [KIND_W-1:0]   i_req_kind,     // kind[1:0]
    input  logic                i_res_valid,
    input  logic                i_res_ready,
    input  logic [DATA_W-1:0]   i_res_data,     // found_start[9:0], used_count[20:10]
    input  logic [STATUS_W-1:0] i_res_status,   // status[1:0]
    output int                  o_fail_count,
    output int                  o_outstanding,
    output int                  o_results,
    output int                  o_done,
    output int                  o_nofit,
    output int                  o_bad
);

    localparam int NONE = -1;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [START_W-1:0]  start;
        logic [LEN_W-1:0]    used;
    } t_outcome;

    // Shadow state of the allocator.
    bit         block_used [BLOCKS];
    int         rover_pos;
    int         blocks_in_use;
    logic [1:0] strategy;

    t_outcome   pending_q[$];
    int         mismatches;
    int         results_seen;
    int         n_done;
    int         n_nofit;
    int         n_bad;

    task automatic report_mismatch(input string what);
        mismatches++;
        $display("[%0t] mismatch on result %0d: %s", $time, results_seen, what);
    endtask

    // End (exclusive) of the free stretch that starts at p, looking no further than lim.
    function automatic int free_stretch_end(int p, int lim);
        int j;
        j = p;
        if (lim > BLOCKS)
            lim = BLOCKS;
        while (j < lim && !block_used[j])
            j++;
        return j;
    endfunction

    function automatic void claim_blocks(int first, int count);
        for (int k = first; k < first + count; k++) begin
            if (!block_used[k]) begin
                block_used[k] = 1'b1;
                blocks_in_use++;
            end
        end
    endfunction

    function automatic int place_first(int len);
        int i;
        int j;
        i = 0;
        while (i < BLOCKS) begin
            if (!block_used[i]) begin
                j = free_stretch_end(i, i + len);
                if (j - i == len)
                    return i;
                i = j;
            end else begin
                i++;
            end
        end
        return NONE;
    endfunction

    // Best fit keeps the smallest hole, later holes winning ties; worst fit keeps the
    // first of the largest holes.
    function automatic int place_sized(int len, bit smallest);
        int i;
        int j;
        int pick;
        int best;
        i = 0;
        pick = NONE;
        best = 0;
        while (i < BLOCKS) begin
            if (!block_used[i]) begin
                j = free_stretch_end(i, BLOCKS);
                if (j - i >= len) begin
                    if (smallest) begin
                        if (pick == NONE || j - i <= best) begin
                            best = j - i;
                            pick = i;
                        end
                    end else if (j - i > best) begin
                        best = j - i;
                        pick = i;
                    end
                end
                i = j;
            end else begin
                i++;
            end
        end
        return pick;
    endfunction

    // Next fit starts at the rover, wraps to block 0 and looks at each position once.
    function automatic int place_next(int len);
        int i;
        int j;
        int seen;
        i = rover_pos;
        seen = 0;
        while (seen < BLOCKS) begin
            if (!block_used[i]) begin
                j = free_stretch_end(i, i + len);
                if (j - i == len) begin
                    rover_pos = j % BLOCKS;
                    return i;
                end
                seen += j - i;
                i = j % BLOCKS;
            end else begin
                seen++;
                i = (i + 1) % BLOCKS;
            end
        end
        return NONE;
    endfunction

    // Applies one request to the shadow state and returns the result it must produce.
    function automatic t_outcome predict_request(logic [KIND_W-1:0] kind, int start, int len);
        t_outcome r;
        int pos;
        r.status = STATUS_BAD;
        r.start = '0;
        if (len != 0 && kind == KIND_ALLOC) begin
            pos = NONE;
            if (len <= BLOCKS) begin
                case (strategy)
                    FIT_FIRST: pos = place_first(len);
                    FIT_BEST:  pos = place_sized(len, 1'b1);
                    FIT_NEXT:  pos = place_next(len);
                    FIT_WORST: pos = place_sized(len, 1'b0);
                endcase
            end
            if (pos == NONE) begin
                r.status = STATUS_NOFIT;
            end else begin
                claim_blocks(pos, len);
                r.status = STATUS_DONE;
                r.start = START_W'(pos);
            end
        end else if (len != 0 && (kind == KIND_FREE || kind == KIND_CLAIM)
                     && start + len <= BLOCKS) begin
            if (kind == KIND_FREE) begin
                // Blocks that are already free stay free and do not count.
                for (int k = start; k < start + len; k++) begin
                    if (block_used[k]) begin
                        block_used[k] = 1'b0;
                        blocks_in_use--;
                    end
                end
                r.status = STATUS_DONE;
                r.start = START_W'(start);
            end else if (free_stretch_end(start, start + len) - start == len) begin
                claim_blocks(start, len);
                r.status = STATUS_DONE;
                r.start = START_W'(start);
            end else begin
                r.status = STATUS_NOFIT;
            end
        end
        r.used = LEN_W'(blocks_in_use);
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_outcome want;
        t_outcome got;
        if (!i_rst_n) begin
            for (int k = 0; k < BLOCKS; k++)
                block_used[k] = 1'b0;
            rover_pos = 0;
            blocks_in_use = 0;
            strategy = FIT_FIRST;
            pending_q.delete();
            mismatches = 0;
            results_seen = 0;
            n_done = 0;
            n_nofit = 0;
            n_bad = 0;
        end else begin
            // Results are handled before requests: a result never belongs to a word
            // taken at the same edge.
            if (i_res_valid && i_res_ready) begin
                got.status = i_res_status;
                got.start = i_res_data[START_W-1:0];
                got.used = i_res_data[START_W +: LEN_W];
                if (pending_q.size() == 0) begin
                    report_mismatch($sformatf("result word with nothing pending (status %0d)",
                                              got.status));
                end else begin
                    want = pending_q.pop_front();
                    if (got.status !== want.status)
                        report_mismatch($sformatf("status want %0d got %0d",
                                                  want.status, got.status));
                    if (got.start !== want.start)
                        report_mismatch($sformatf("found_start want %0d got %0d",
                                                  want.start, got.start));
                    if (got.used !== want.used)
                        report_mismatch($sformatf("used_count want %0d got %0d",
                                                  want.used, got.used));
                end
                results_seen++;
            end

            if (i_cfg_valid && i_cfg_ready)
                strategy = i_cfg_data;

            if (i_req_valid && i_req_ready) begin
                want = predict_request(i_req_kind, int'(i_req_data[START_W-1:0]),
                                       int'(i_req_data[START_W +: LEN_W]));
                case (want.status)
                    STATUS_DONE:  n_done++;
                    STATUS_NOFIT: n_nofit++;
                    default:      n_bad++;
                endcase
                pending_q.push_back(want);
            end
        end

        o_fail_count  <= mismatches;
        o_outstanding <= pending_q.size();
        o_results     <= results_seen;
        o_done        <= n_done;
        o_nofit       <= n_nofit;
        o_bad         <= n_bad;
    end

endmodule

FILE: sim/tb_top.sv
`timescale 1ns / 1ps

// Drives request words into the allocator under each fit strategy, idles both channels at
// random and gives the verdict from the checker's counts.
module tb_top;
    import cfba_pkg::*;

    localparam int BLOCKS     = 1024;
    localparam int LONG_HOLD  = 400;
    localparam int PHASE_SIZE = 70;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_cfg_valid = 1'b0;
    logic                o_cfg_ready;
    logic [1:0]          i_cfg_data = FIT_FIRST;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [DATA_W-1:0]   s_axis_tdata = '0;     // run_start[9:0], run_length[20:10]
    logic [KIND_W-1:0]   s_axis_tuser = '0;     // kind[1:0]
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [DATA_W-1:0]   m_axis_tdata;          // found_start[9:0], used_count[20:10]
    logic [STATUS_W-1:0] m_axis_tuser;          // status[1:0]

    int fail_count;
    int outstanding;
    int results_seen;
    int n_done;
    int n_nofit;
    int n_bad;

    int n_sent = 0;
    bit sender_quiet = 1'b0;

    contiguous_fit_block_allocator #(
        .BLOCKS(BLOCKS)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    allocator_checker #(
        .BLOCKS(BLOCKS)
    ) checker_i (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .i_req_valid   (s_axis_tvalid),
        .i_req_ready   (s_axis_tready),
        .i_req_data    (s_axis_tdata),
        .i_req_kind    (s_axis_tuser),
        .i_res_valid   (m_axis_tvalid),
        .i_res_ready   (m_axis_tready),
        .i_res_data    (m_axis_tdata),
        .i_res_status  (m_axis_tuser),
        .o_fail_count  (fail_count),
        .o_outstanding (outstanding),
        .o_results     (results_seen),
        .o_done        (n_done),
        .o_nofit       (n_nofit),
        .o_bad         (n_bad)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // Mostly no gap, often a short one, now and then a long one.
    function automatic int idle_span();
        int roll;
        roll = $urandom_range(99);
        if (roll < 60)
            return 0;
        if (roll < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Offers one request word and returns at the edge that takes it.
    task automatic send_request(input logic [KIND_W-1:0] kind, input logic [START_W-1:0] start,
                                input logic [LEN_W-1:0] len);
        int gap;
        gap = sender_quiet ? 0 : idle_span();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tdata  <= {{PAD_W{1'b0}}, len, start};
        s_axis_tuser  <= kind;
        s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        n_sent++;
    endtask

    // Lets every pending result arrive, then writes the fit strategy.
    task automatic set_strategy(input logic [1:0] code);
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (outstanding != 0);
        i_cfg_data  <= code;
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic int pick_length();
        int roll;
        roll = $urandom_range(99);
        if (roll < 70)
            return $urandom_range(1, 16);
        if (roll < 92)
            return $urandom_range(17, 96);
        if (roll < 98)
            return $urandom_range(97, 512);
        return $urandom_range(513, BLOCKS);
    endfunction

    // Mostly well-formed requests; frees run longer so the map keeps turning over.
    task automatic send_random_request();
        int roll;
        int len;
        int start;
        logic [KIND_W-1:0] kind;
        roll = $urandom_range(99);
        len = pick_length();
        if (roll < 46) begin
            kind = KIND_ALLOC;
            start = $urandom_range(BLOCKS - 1);
        end else if (roll < 94) begin
            kind = (roll < 76) ? KIND_FREE : KIND_CLAIM;
            if (kind == KIND_FREE)
                len = (len * $urandom_range(1, 4) > BLOCKS) ? BLOCKS : len * $urandom_range(1, 4);
            if (kind == KIND_FREE && $urandom_range(49) == 0) begin
                start = 0;
                len = BLOCKS;
            end else begin
                start = $urandom_range(BLOCKS - len);
            end
        end else begin
            // Malformed: zero length, oversize length, a run past the end or an unknown kind.
            kind = $urandom_range(3);
            start = $urandom_range(BLOCKS - 1);
            case ($urandom_range(2))
                0: len = 0;
                1: len = $urandom_range((1 << LEN_W) - 1);
                default: begin
                    start = BLOCKS - 1 - $urandom_range(7);
                    len = BLOCKS - start + 1 + $urandom_range(20);
                end
            endcase
        end
        send_request(kind, START_W'(start), LEN_W'(len));
    endtask

    // Result side: random gaps, quiet stretches, and two long hold-offs while requests
    // keep coming so that the block backs up into its input.
    initial begin : result_sink
        int cyc;
        int span;
        int holds;
        cyc = 0;
        holds = 0;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (holds < 2 && results_seen >= (holds == 0 ? 150 : 420) && s_axis_tvalid) begin
                holds++;
                m_axis_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
            end else begin
                m_axis_tready <= 1'b1;
                @(posedge i_clk);
                span = ((cyc / 300) % 4 == 3) ? 0 : idle_span();
                if (span > 0) begin
                    m_axis_tready <= 1'b0;
                    repeat (span) @(posedge i_clk);
                end
            end
            cyc++;
        end
    end

    initial begin : stimulus
        logic [1:0] plan [8];
        plan = '{FIT_FIRST, FIT_BEST, FIT_NEXT, FIT_WORST,
                 FIT_WORST, FIT_NEXT, FIT_BEST, FIT_FIRST};

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        set_strategy(FIT_FIRST);

        // Malformed requests: zero length for every kind, unknown kind, oversize runs.
        send_request(KIND_ALLOC, 10'd0, 11'd0);
        send_request(KIND_FREE, 10'd5, 11'd0);
        send_request(KIND_CLAIM, 10'd5, 11'd0);
        send_request(2'd3, 10'd0, 11'd4);
        send_request(KIND_ALLOC, 10'd0, 11'd2047);
        send_request(KIND_FREE, 10'd1023, 11'd2047);
        // Whole store taken, then nothing fits and a claim over used blocks fails.
        send_request(KIND_ALLOC, 10'd0, 11'd1024);
        send_request(KIND_ALLOC, 10'd0, 11'd1);
        send_request(KIND_CLAIM, 10'd0, 11'd1);
        send_request(KIND_FREE, 10'd0, 11'd1024);
        // Freeing blocks that are already free leaves the count alone.
        send_request(KIND_FREE, 10'd0, 11'd4);
        send_request(KIND_CLAIM, 10'd1023, 11'd1);
        send_request(KIND_CLAIM, 10'd1023, 11'd2);
        send_request(KIND_ALLOC, 10'd0, 11'd1024);
        send_request(KIND_ALLOC, 10'd0, 11'd1023);
        // Open holes of 5, 3, 10, 3 and 10 blocks so that size ties exist.
        send_request(KIND_FREE, 10'd100, 11'd5);
        send_request(KIND_FREE, 10'd200, 11'd3);
        send_request(KIND_FREE, 10'd500, 11'd10);
        send_request(KIND_FREE, 10'd700, 11'd3);
        send_request(KIND_FREE, 10'd900, 11'd10);
        // Best fit takes the later of two equal holes, worst fit the first.
        set_strategy(FIT_BEST);
        send_request(KIND_ALLOC, 10'd0, 11'd3);
        set_strategy(FIT_WORST);
        send_request(KIND_ALLOC, 10'd0, 11'd2);
        // Next fit moves its rover along the holes.
        set_strategy(FIT_NEXT);
        send_request(KIND_ALLOC, 10'd0, 11'd4);
        send_request(KIND_ALLOC, 10'd0, 11'd4);
        send_request(KIND_ALLOC, 10'd0, 11'd9);

        // Random phases, one per strategy setting; the third has no sender gaps.
        foreach (plan[p]) begin
            set_strategy(plan[p]);
            sender_quiet = (p == 2);
            repeat (PHASE_SIZE) send_random_request();
        end

        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (outstanding != 0);
        // Room for any stray result a full scan could still produce.
        repeat (2 * BLOCKS + 64) @(posedge i_clk);

        $display("Covered %0d requests over all four fit strategies, with long result stalls.",
                 n_sent);
        $display("Outcomes: %0d done, %0d without room, %0d malformed; %0d results checked.",
                 n_done, n_nofit, n_bad, results_seen);
        if (fail_count == 0 && outstanding == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    initial begin : watchdog
        #150_000_000;
        $display("Timeout with %0d results still outstanding.", outstanding);
        $display("TB_ERROR");
        $finish;
    end

endmodule
